>>> hw/rtl/face_normal_outward_unit_macros.svh
// Assertion macros for the face normal top level.
`ifndef FACE_NORMAL_OUTWARD_UNIT_MACROS_SVH
`define FACE_NORMAL_OUTWARD_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define FNO_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("face normal check failed");
// Check that cons holds in the cycle after ante.
`define FNO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("face normal check failed");
`else
`define FNO_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FNO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/fno_pkg.sv
// Types, widths and register codes of the face normal unit.
`default_nettype none
package fno_pkg;
   // field widths
   localparam int CRD_W   = 32;
   localparam int SLOT_W  = 10;
   localparam int NRM_W   = 16;
   // datapath widths
   localparam int DIF_W   = CRD_W + 1;
   localparam int PRD_W   = 2 * DIF_W;
   localparam int CRS_W   = PRD_W + 1;
   localparam int CTR_W   = CRD_W + 4;
   localparam int MAG_W   = 31;
   localparam int SQR_W   = 64;
   localparam int ROOT_W  = 32;
   localparam int QUO_W   = 15;
   localparam int NUM_W   = MAG_W + QUO_W + 1;
   localparam int DEN_W   = ROOT_W + 1;
   localparam int POS_W   = 7;
   localparam int CHUNK_N = 9;
   localparam int PROD_W  = NRM_W + CTR_W;
   localparam int DOT_W   = PROD_W + 2;
   localparam int DIV_LAT = QUO_W + 1;

   localparam int NORMAL_SLOTS_DEF = 1024;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = CSR_IDX_W'(2);

   typedef struct packed {
      logic signed [CRD_W-1:0] a_x;
      logic signed [CRD_W-1:0] a_y;
      logic signed [CRD_W-1:0] a_z;
      logic signed [CRD_W-1:0] b_x;
      logic signed [CRD_W-1:0] b_y;
      logic signed [CRD_W-1:0] b_z;
      logic signed [CRD_W-1:0] c_x;
      logic signed [CRD_W-1:0] c_y;
      logic signed [CRD_W-1:0] c_z;
      logic [SLOT_W-1:0]       slot_in;
   } req_type;

   typedef struct packed {
      logic signed [NRM_W-1:0] norm_x;
      logic signed [NRM_W-1:0] norm_y;
      logic signed [NRM_W-1:0] norm_z;
      logic [SLOT_W-1:0]       slot_out;
      logic                    degenerate;
   } rsp_type;

   // per-word data that rides beside the normal datapath
   typedef struct packed {
      logic [2:0]              neg;
      logic signed [CTR_W-1:0] s_x;
      logic signed [CTR_W-1:0] s_y;
      logic signed [CTR_W-1:0] s_z;
      logic [SLOT_W-1:0]       slot;
   } side_type;

   typedef struct packed {
      logic [MAG_W-1:0] m_x;
      logic [MAG_W-1:0] m_y;
      logic [MAG_W-1:0] m_z;
      logic             degen;
      side_type         side;
   } trail_type;
endpackage
`default_nettype wire

>>> hw/rtl/fno_front.sv
// Front stages: edge vectors, centroid offset, cross product magnitudes.
`default_nettype none
module fno_front #(
   parameter int NORMAL_SLOTS = fno_pkg::NORMAL_SLOTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  fno_pkg::req_type                   in_data,
   input  logic signed [fno_pkg::CRD_W-1:0]   center_x,
   input  logic signed [fno_pkg::CRD_W-1:0]   center_y,
   input  logic signed [fno_pkg::CRD_W-1:0]   center_z,
   output logic                               out_valid,
   output logic [fno_pkg::CRS_W-1:0]          out_mag_x,
   output logic [fno_pkg::CRS_W-1:0]          out_mag_y,
   output logic [fno_pkg::CRS_W-1:0]          out_mag_z,
   output fno_pkg::side_type                  out_side
);
   localparam int CRD_W  = fno_pkg::CRD_W;
   localparam int DIF_W  = fno_pkg::DIF_W;
   localparam int PRD_W  = fno_pkg::PRD_W;
   localparam int CRS_W  = fno_pkg::CRS_W;
   localparam int CTR_W  = fno_pkg::CTR_W;
   localparam int SLOT_W = fno_pkg::SLOT_W;

   logic signed [CRD_W-1:0] pa [3];
   logic signed [CRD_W-1:0] pb [3];
   logic signed [CRD_W-1:0] pc [3];
   logic signed [CRD_W-1:0] ctr [3];

   logic signed [DIF_W-1:0] u_in [3];
   logic signed [DIF_W-1:0] w_in [3];
   logic signed [CTR_W-1:0] s_in [3];
   logic [SLOT_W-1:0]       slot1_in;
   logic signed [DIF_W-1:0] u_ff [3];
   logic signed [DIF_W-1:0] w_ff [3];
   logic signed [CTR_W-1:0] s1_ff [3];
   logic [SLOT_W-1:0]       slot1_ff;
   logic                    v1_ff;

   logic signed [PRD_W-1:0] p_in [6];
   logic [SLOT_W-1:0]       slot2_in;
   logic signed [PRD_W-1:0] p_ff [6];
   logic signed [CTR_W-1:0] s2_ff [3];
   logic [SLOT_W-1:0]       slot2_ff;
   logic                    v2_ff;

   logic signed [CRS_W-1:0] n_in [3];
   logic [CRS_W-1:0]        mag_in [3];
   logic [2:0]              neg_in;
   logic [CRS_W-1:0]        mag_ff [3];
   fno_pkg::side_type       side_ff;
   logic                    v3_ff;

   assign pa[0] = in_data.a_x;
   assign pa[1] = in_data.a_y;
   assign pa[2] = in_data.a_z;
   assign pb[0] = in_data.b_x;
   assign pb[1] = in_data.b_y;
   assign pb[2] = in_data.b_z;
   assign pc[0] = in_data.c_x;
   assign pc[1] = in_data.c_y;
   assign pc[2] = in_data.c_z;
   assign ctr[0] = center_x;
   assign ctr[1] = center_y;
   assign ctr[2] = center_z;

   // stage 1: edges, three times centroid minus center, upper slot folds
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i] = DIF_W'(pa[i]) - DIF_W'(pb[i]);
         w_in[i] = DIF_W'(pa[i]) - DIF_W'(pc[i]);
         s_in[i] = CTR_W'(pa[i]) + CTR_W'(pb[i]) + CTR_W'(pc[i])
                   - ((CTR_W'(ctr[i]) <<< 1) + CTR_W'(ctr[i]));
      end
      slot1_in = in_data.slot_in;
      for (int k = SLOT_W - 1; k >= SLOT_W / 2; k--) begin
         if (32'(slot1_in) >= (32'(NORMAL_SLOTS) << k)) begin
            slot1_in = slot1_in - SLOT_W'(32'(NORMAL_SLOTS) << k);
         end
      end
   end

   // stage 2: six partial cross products, lower slot folds
   always_comb begin
      p_in[0] = u_ff[1] * w_ff[2];
      p_in[1] = u_ff[2] * w_ff[1];
      p_in[2] = u_ff[2] * w_ff[0];
      p_in[3] = u_ff[0] * w_ff[2];
      p_in[4] = u_ff[0] * w_ff[1];
      p_in[5] = u_ff[1] * w_ff[0];
      slot2_in = slot1_ff;
      for (int k = SLOT_W / 2 - 1; k >= 0; k--) begin
         if (32'(slot2_in) >= (32'(NORMAL_SLOTS) << k)) begin
            slot2_in = slot2_in - SLOT_W'(32'(NORMAL_SLOTS) << k);
         end
      end
   end

   // stage 3: cross components, split into sign and magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i]   = CRS_W'(p_ff[2*i]) - CRS_W'(p_ff[2*i+1]);
         neg_in[i] = n_in[i][CRS_W-1];
         mag_in[i] = neg_in[i] ? CRS_W'(-n_in[i]) : CRS_W'(n_in[i]);
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            u_ff[i]   <= u_in[i];
            w_ff[i]   <= w_in[i];
            s1_ff[i]  <= s_in[i];
            s2_ff[i]  <= s1_ff[i];
            mag_ff[i] <= mag_in[i];
         end
         for (int j = 0; j < 6; j++) begin
            p_ff[j] <= p_in[j];
         end
         slot1_ff     <= slot1_in;
         slot2_ff     <= slot2_in;
         side_ff.neg  <= neg_in;
         side_ff.s_x  <= s2_ff[0];
         side_ff.s_y  <= s2_ff[1];
         side_ff.s_z  <= s2_ff[2];
         side_ff.slot <= slot2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_mag_x = mag_ff[0];
   assign out_mag_y = mag_ff[1];
   assign out_mag_z = mag_ff[2];
   assign out_side  = side_ff;
endmodule
`default_nettype wire

>>> hw/rtl/fno_norm.sv
// Scaling stages: leading-one search, common shift, sum of squares.
`default_nettype none
module fno_norm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [fno_pkg::CRS_W-1:0]   in_mag_x,
   input  logic [fno_pkg::CRS_W-1:0]   in_mag_y,
   input  logic [fno_pkg::CRS_W-1:0]   in_mag_z,
   input  fno_pkg::side_type           in_side,
   output logic                        out_valid,
   output logic [fno_pkg::SQR_W-1:0]   out_sum,
   output fno_pkg::trail_type          out_trail
);
   localparam int CRS_W   = fno_pkg::CRS_W;
   localparam int MAG_W   = fno_pkg::MAG_W;
   localparam int SQR_W   = fno_pkg::SQR_W;
   localparam int POS_W   = fno_pkg::POS_W;
   localparam int CHUNK_N = fno_pkg::CHUNK_N;
   localparam int PAD_W   = CHUNK_N * 8;
   localparam int SHF_W   = CRS_W + MAG_W - 1;
   localparam int SQ_W    = 2 * MAG_W;

   logic [PAD_W-1:0]   or_all;
   logic [CHUNK_N-1:0] nz_in;
   logic [2:0]         pos_in [CHUNK_N];
   logic [CHUNK_N-1:0] nz_ff;
   logic [2:0]         pos_ff [CHUNK_N];
   logic [CRS_W-1:0]   mag1_ff [3];
   fno_pkg::side_type  side1_ff;
   logic               v1_ff;

   logic [POS_W-1:0]   lead_in;
   logic [POS_W-1:0]   lead_ff;
   logic [CRS_W-1:0]   mag2_ff [3];
   logic               degen2_ff;
   fno_pkg::side_type  side2_ff;
   logic               v2_ff;

   logic [SHF_W-1:0]   shf [3];
   logic [MAG_W-1:0]   m_in [3];
   fno_pkg::trail_type t3_ff;
   logic               v3_ff;

   logic [SQ_W-1:0]    sq_ff [3];
   fno_pkg::trail_type t4_ff;
   logic               v4_ff;

   logic [SQR_W-1:0]   sum_ff;
   fno_pkg::trail_type t5_ff;
   logic               v5_ff;

   // N1: per-byte nonzero flags and highest set bit in each byte
   always_comb begin
      or_all = {(PAD_W - CRS_W)'(0), in_mag_x | in_mag_y | in_mag_z};
      for (int c = 0; c < CHUNK_N; c++) begin
         nz_in[c]  = |or_all[c*8 +: 8];
         pos_in[c] = 3'd0;
         for (int b = 0; b < 8; b++) begin
            if (or_all[c*8 + b]) begin
               pos_in[c] = 3'(b);
            end
         end
      end
   end

   // N2: pick the highest nonzero byte
   always_comb begin
      lead_in = '0;
      for (int c = 0; c < CHUNK_N; c++) begin
         if (nz_ff[c]) begin
            lead_in = POS_W'(c * 8) | POS_W'(pos_ff[c]);
         end
      end
   end

   // N3: move the leading one of the largest magnitude to the top bit
   always_comb begin
      shf[0] = {mag2_ff[0], (MAG_W - 1)'(0)} >> lead_ff;
      shf[1] = {mag2_ff[1], (MAG_W - 1)'(0)} >> lead_ff;
      shf[2] = {mag2_ff[2], (MAG_W - 1)'(0)} >> lead_ff;
      for (int i = 0; i < 3; i++) begin
         m_in[i] = shf[i][MAG_W-1:0];
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         nz_ff      <= nz_in;
         for (int c = 0; c < CHUNK_N; c++) begin
            pos_ff[c] <= pos_in[c];
         end
         mag1_ff[0] <= in_mag_x;
         mag1_ff[1] <= in_mag_y;
         mag1_ff[2] <= in_mag_z;
         side1_ff   <= in_side;
         lead_ff    <= lead_in;
         for (int i = 0; i < 3; i++) begin
            mag2_ff[i] <= mag1_ff[i];
         end
         degen2_ff  <= ~|nz_ff;
         side2_ff   <= side1_ff;
         t3_ff.m_x  <= m_in[0];
         t3_ff.m_y  <= m_in[1];
         t3_ff.m_z  <= m_in[2];
         t3_ff.degen <= degen2_ff;
         t3_ff.side <= side2_ff;
         // square the scaled magnitudes one stage behind the shift
         sq_ff[0]   <= SQ_W'(t3_ff.m_x) * SQ_W'(t3_ff.m_x);
         sq_ff[1]   <= SQ_W'(t3_ff.m_y) * SQ_W'(t3_ff.m_y);
         sq_ff[2]   <= SQ_W'(t3_ff.m_z) * SQ_W'(t3_ff.m_z);
         t4_ff      <= t3_ff;
         sum_ff     <= SQR_W'(sq_ff[0]) + SQR_W'(sq_ff[1]) + SQR_W'(sq_ff[2]);
         t5_ff      <= t4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign out_sum   = sum_ff;
   assign out_trail = t5_ff;
endmodule
`default_nettype wire

>>> hw/rtl/fno_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module fno_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [fno_pkg::SQR_W-1:0]   in_x,
   input  fno_pkg::trail_type          in_trail,
   output logic                        out_valid,
   output logic [fno_pkg::ROOT_W-1:0]  out_root,
   output fno_pkg::trail_type          out_trail
);
   localparam int SQR_W  = fno_pkg::SQR_W;
   localparam int ROOT_W = fno_pkg::ROOT_W;
   localparam int REM_W  = ROOT_W + 2;

   logic [SQR_W-1:0]   x_cur [ROOT_W];
   logic [REM_W-1:0]   rem_cur [ROOT_W];
   logic [ROOT_W-1:0]  root_cur [ROOT_W];
   fno_pkg::trail_type t_cur [ROOT_W];
   logic               v_cur [ROOT_W];

   logic [SQR_W-1:0]   x_in [ROOT_W];
   logic [REM_W-1:0]   rem_in [ROOT_W];
   logic [ROOT_W-1:0]  root_in [ROOT_W];

   logic [SQR_W-1:0]   x_ff [ROOT_W];
   logic [REM_W-1:0]   rem_ff [ROOT_W];
   logic [ROOT_W-1:0]  root_ff [ROOT_W];
   fno_pkg::trail_type t_ff [ROOT_W];
   logic               v_ff [ROOT_W];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_step
      logic [REM_W+1:0] r2;
      logic [REM_W+1:0] trial;

      // select the stage source
      if (g == 0) begin : g_head
         assign x_cur[g]    = in_x;
         assign rem_cur[g]  = '0;
         assign root_cur[g] = '0;
         assign t_cur[g]    = in_trail;
         assign v_cur[g]    = in_valid;
      end else begin : g_body
         assign x_cur[g]    = x_ff[g-1];
         assign rem_cur[g]  = rem_ff[g-1];
         assign root_cur[g] = root_ff[g-1];
         assign t_cur[g]    = t_ff[g-1];
         assign v_cur[g]    = v_ff[g-1];
      end

      // bring down two radicand bits and try the next root bit
      assign r2    = {rem_cur[g], x_cur[g][SQR_W-1 -: 2]};
      assign trial = {2'b00, root_cur[g], 2'b01};

      always_comb begin
         x_in[g] = x_cur[g] << 2;
         if (r2 >= trial) begin
            rem_in[g]  = REM_W'(r2 - trial);
            root_in[g] = {root_cur[g][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[g]  = r2[REM_W-1:0];
            root_in[g] = {root_cur[g][ROOT_W-2:0], 1'b0};
         end
      end

      // advance valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= v_cur[g];
         end
      end

      // advance payload
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[g]    <= x_in[g];
            rem_ff[g]  <= rem_in[g];
            root_ff[g] <= root_in[g];
            t_ff[g]    <= t_cur[g];
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_trail = t_ff[ROOT_W-1];
endmodule
`default_nettype wire

>>> hw/rtl/fno_div.sv
// One lane of the rounded unit-length divide, one quotient bit per stage.
`default_nettype none
module fno_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [fno_pkg::MAG_W-1:0]   in_m,
   input  logic [fno_pkg::ROOT_W-1:0]  in_len,
   output logic [fno_pkg::QUO_W-1:0]   out_quo
);
   localparam int MAG_W  = fno_pkg::MAG_W;
   localparam int QUO_W  = fno_pkg::QUO_W;
   localparam int NUM_W  = fno_pkg::NUM_W;
   localparam int DEN_W  = fno_pkg::DEN_W;
   localparam int REM_W  = DEN_W;

   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;

   logic [REM_W-1:0]  rem_cur [QUO_W];
   logic [QUO_W-1:0]  lo_cur [QUO_W];
   logic [QUO_W-1:0]  q_cur [QUO_W];
   logic [REM_W-1:0]  rem_in [QUO_W];
   logic [QUO_W-1:0]  lo_in [QUO_W];
   logic [QUO_W-1:0]  q_in [QUO_W];
   logic [REM_W-1:0]  rem_ff [QUO_W];
   logic [QUO_W-1:0]  lo_ff [QUO_W];
   logic [QUO_W-1:0]  q_ff [QUO_W];
   logic [DEN_W-1:0]  den_pipe_ff [QUO_W];
   logic [DEN_W-1:0]  den_cur [QUO_W];

   // form m * 2^15 + len over 2 * len
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= NUM_W'({in_m, QUO_W'(0)}) + NUM_W'(in_len);
         den_ff <= {in_len, 1'b0};
      end
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_step
      logic [REM_W:0] r2;

      if (g == 0) begin : g_head
         assign rem_cur[g] = REM_W'(num_ff[NUM_W-1:QUO_W]);
         assign lo_cur[g]  = num_ff[QUO_W-1:0];
         assign q_cur[g]   = '0;
         assign den_cur[g] = den_ff;
      end else begin : g_body
         assign rem_cur[g] = rem_ff[g-1];
         assign lo_cur[g]  = lo_ff[g-1];
         assign q_cur[g]   = q_ff[g-1];
         assign den_cur[g] = den_pipe_ff[g-1];
      end

      // shift in the next numerator bit and subtract when it fits
      assign r2 = {rem_cur[g], lo_cur[g][QUO_W-1]};

      always_comb begin
         lo_in[g] = lo_cur[g] << 1;
         if (r2 >= {1'b0, den_cur[g]}) begin
            rem_in[g] = REM_W'(r2 - {1'b0, den_cur[g]});
            q_in[g]   = {q_cur[g][QUO_W-2:0], 1'b1};
         end else begin
            rem_in[g] = r2[REM_W-1:0];
            q_in[g]   = {q_cur[g][QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]      <= rem_in[g];
            lo_ff[g]       <= lo_in[g];
            q_ff[g]        <= q_in[g];
            den_pipe_ff[g] <= den_cur[g];
         end
      end
   end

   assign out_quo = q_ff[QUO_W-1];
endmodule
`default_nettype wire

>>> hw/rtl/face_normal_outward_unit.sv
// Top level of the triangle face normal unit with outward orientation.
`default_nettype none
`include "face_normal_outward_unit_macros.svh"
// Takes one triangle per clock while not stalled and returns its unit normal in
// Q1.14, turned to face away from the mesh center held in the center_x/y/z
// registers. Every word gives exactly one result word, in order; most of the
// depth lies in the 32-stage square root and the 16-stage rounded divide that
// scale the cross product to unit length. A stall on the result side while a
// result is held freezes the whole pipeline and raises req_stall in the same
// cycle; nothing is lost or repeated. Degenerate triangles (zero cross
// product) return a zero normal with degenerate set. Write the center
// registers only while no word is in flight.
module face_normal_outward_unit #(
   parameter int NORMAL_SLOTS = fno_pkg::NORMAL_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  fno_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output fno_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [fno_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fno_pkg::CRD_W-1:0]         csr_data
);
   localparam int CRD_W   = fno_pkg::CRD_W;
   localparam int CRS_W   = fno_pkg::CRS_W;
   localparam int SQR_W   = fno_pkg::SQR_W;
   localparam int ROOT_W  = fno_pkg::ROOT_W;
   localparam int QUO_W   = fno_pkg::QUO_W;
   localparam int NRM_W   = fno_pkg::NRM_W;
   localparam int PROD_W  = fno_pkg::PROD_W;
   localparam int DOT_W   = fno_pkg::DOT_W;
   localparam int SLOT_W  = fno_pkg::SLOT_W;
   localparam int DIV_LAT = fno_pkg::DIV_LAT;

   logic                    en;
   logic signed [CRD_W-1:0] center_x_ff;
   logic signed [CRD_W-1:0] center_y_ff;
   logic signed [CRD_W-1:0] center_z_ff;

   logic                    fr_valid;
   logic [CRS_W-1:0]        fr_mag_x;
   logic [CRS_W-1:0]        fr_mag_y;
   logic [CRS_W-1:0]        fr_mag_z;
   fno_pkg::side_type       fr_side;

   logic                    nm_valid;
   logic [SQR_W-1:0]        nm_sum;
   fno_pkg::trail_type      nm_trail;

   logic                    sq_valid;
   logic [ROOT_W-1:0]       sq_root;
   fno_pkg::trail_type      sq_trail;

   logic [QUO_W-1:0]        quo [3];
   fno_pkg::trail_type      line_ff [DIV_LAT];
   logic                    line_v_ff [DIV_LAT];
   fno_pkg::trail_type      tail;

   logic signed [NRM_W-1:0]  q_in [3];
   logic signed [CRD_W+3:0]  s_sel [3];
   logic signed [NRM_W-1:0]  q_ff [3];
   logic signed [PROD_W-1:0] prod_ff [3];
   logic                     degen_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic                     o1_valid_ff;

   logic signed [DOT_W-1:0]  dot;
   logic                     flip;
   fno_pkg::rsp_type         rsp_in;
   fno_pkg::rsp_type         rsp_data_ff;
   logic                     rsp_valid_ff;

   // the whole pipe moves unless a finished word is held
   assign en        = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~en;

   // center registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            fno_pkg::CSR_CENTER_X: center_x_ff <= csr_data;
            fno_pkg::CSR_CENTER_Y: center_y_ff <= csr_data;
            fno_pkg::CSR_CENTER_Z: center_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   fno_front #(
      .NORMAL_SLOTS (NORMAL_SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .center_z  (center_z_ff),
      .out_valid (fr_valid),
      .out_mag_x (fr_mag_x),
      .out_mag_y (fr_mag_y),
      .out_mag_z (fr_mag_z),
      .out_side  (fr_side)
   );

   fno_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_mag_x  (fr_mag_x),
      .in_mag_y  (fr_mag_y),
      .in_mag_z  (fr_mag_z),
      .in_side   (fr_side),
      .out_valid (nm_valid),
      .out_sum   (nm_sum),
      .out_trail (nm_trail)
   );

   fno_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nm_valid),
      .in_x      (nm_sum),
      .in_trail  (nm_trail),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_trail (sq_trail)
   );

   fno_div u_div_x (
      .clock   (clock),
      .en      (en),
      .in_m    (sq_trail.m_x),
      .in_len  (sq_root),
      .out_quo (quo[0])
   );

   fno_div u_div_y (
      .clock   (clock),
      .en      (en),
      .in_m    (sq_trail.m_y),
      .in_len  (sq_root),
      .out_quo (quo[1])
   );

   fno_div u_div_z (
      .clock   (clock),
      .en      (en),
      .in_m    (sq_trail.m_z),
      .in_len  (sq_root),
      .out_quo (quo[2])
   );

   // delay line beside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            line_v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         line_v_ff[0] <= sq_valid;
         for (int k = 1; k < DIV_LAT; k++) begin
            line_v_ff[k] <= line_v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= sq_trail;
         for (int k = 1; k < DIV_LAT; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   assign tail     = line_ff[DIV_LAT-1];
   assign s_sel[0] = tail.side.s_x;
   assign s_sel[1] = tail.side.s_y;
   assign s_sel[2] = tail.side.s_z;

   // apply the cross product signs
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_in[i] = tail.side.neg[i] ? NRM_W'(0) - NRM_W'({1'b0, quo[i]})
                                    : NRM_W'({1'b0, quo[i]});
      end
   end

   // orientation products against the centroid offset
   always_ff @(posedge clock) begin
      if (reset) begin
         o1_valid_ff <= 1'b0;
      end else if (en) begin
         o1_valid_ff <= line_v_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            q_ff[i]    <= q_in[i];
            prod_ff[i] <= q_in[i] * s_sel[i];
         end
         degen_ff <= tail.degen;
         slot_ff  <= tail.side.slot;
      end
   end

   // sum the dot product, flip when it is negative, zero when degenerate
   always_comb begin
      dot  = DOT_W'(prod_ff[0]) + DOT_W'(prod_ff[1]) + DOT_W'(prod_ff[2]);
      flip = dot[DOT_W-1];
      rsp_in.slot_out   = slot_ff;
      rsp_in.degenerate = degen_ff;
      if (degen_ff) begin
         rsp_in.norm_x = '0;
         rsp_in.norm_y = '0;
         rsp_in.norm_z = '0;
      end else if (flip) begin
         rsp_in.norm_x = -q_ff[0];
         rsp_in.norm_y = -q_ff[1];
         rsp_in.norm_z = -q_ff[2];
      end else begin
         rsp_in.norm_x = q_ff[0];
         rsp_in.norm_y = q_ff[1];
         rsp_in.norm_z = q_ff[2];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= o1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FNO_ASSERT_IMPLY(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate, rsp_data.norm_x == 0 && rsp_data.norm_y == 0 && rsp_data.norm_z == 0)
   `FNO_ASSERT_IMPLY(a_norm_range, clock, reset, rsp_valid && !rsp_data.degenerate, rsp_data.norm_x <= 16'sd16384 && rsp_data.norm_x >= -16'sd16384 && rsp_data.norm_y <= 16'sd16384 && rsp_data.norm_y >= -16'sd16384 && rsp_data.norm_z <= 16'sd16384 && rsp_data.norm_z >= -16'sd16384)
   `FNO_ASSERT_IMPLY(a_norm_nonzero, clock, reset, rsp_valid && !rsp_data.degenerate, rsp_data.norm_x != 0 || rsp_data.norm_y != 0 || rsp_data.norm_z != 0)
   `FNO_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   `FNO_ASSERT_NEXT(a_out_load, clock, reset, en && o1_valid_ff, rsp_valid)
endmodule
`default_nettype wire
